// ===== src/poc_pkg.sv =====
// ----------------------------------------------------------------------------
// Pattern occurrence counter package
// Shared widths, register indexes, reset values and payload types.
// ----------------------------------------------------------------------------
package poc_pkg;

  localparam int SYMBOL_W   = 16;
  localparam int OCC_W      = 16;
  localparam int SUPPORT_W  = 32;
  localparam int LENGTH_W   = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ITEM_REGS  = 4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_ITEM_0 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_SUPPORT    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_SUPPORT    = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [LENGTH_W-1:0]  RST_PATTERN_LENGTH = 3'd2;
  localparam logic [SUPPORT_W-1:0] RST_MIN_SUPPORT    = 32'd50;
  localparam logic [SUPPORT_W-1:0] RST_MAX_SUPPORT    = 32'd200;

  typedef struct packed {
    logic [SUPPORT_W-1:0] min_support;
    logic [SUPPORT_W-1:0] max_support;
  } poc_limits_t;

  typedef struct packed {
    logic [OCC_W-1:0]     sequence_occurrences;
    logic [SUPPORT_W-1:0] total_support;
    logic                 database_done;
    logic                 meets_min;
    logic                 within_range;
  } poc_result_t;

endpackage

// ===== src/poc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the pattern, its length and the support limits; derives the index
// of the last pattern position in use.
// ----------------------------------------------------------------------------
module poc_cfg_regs #(
  parameter int MAX_PATTERN_LEN = 4,
  parameter int IDX_W = $clog2(MAX_PATTERN_LEN)
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            cfg_valid,
  input  logic [poc_pkg::CFG_INDEX_W-1:0]                 cfg_index,
  input  logic [poc_pkg::CFG_DATA_W-1:0]                  cfg_data,
  output logic [MAX_PATTERN_LEN-1:0][poc_pkg::SYMBOL_W-1:0] items,
  output logic [IDX_W-1:0]                                last_pos,
  output poc_pkg::poc_limits_t                            limits
);

  logic [poc_pkg::LENGTH_W-1:0] pattern_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length     <= poc_pkg::RST_PATTERN_LENGTH;
      items              <= '0;
      limits.min_support <= poc_pkg::RST_MIN_SUPPORT;
      limits.max_support <= poc_pkg::RST_MAX_SUPPORT;
    end else if (cfg_valid) begin
      case (cfg_index)
        poc_pkg::REG_PATTERN_LENGTH: begin
          pattern_length <= cfg_data[poc_pkg::LENGTH_W-1:0];
        end
        poc_pkg::REG_MIN_SUPPORT: begin
          limits.min_support <= cfg_data;
        end
        poc_pkg::REG_MAX_SUPPORT: begin
          limits.max_support <= cfg_data;
        end
        default: begin
          // Item registers follow the length register in index order.
          for (int p = 0; p < MAX_PATTERN_LEN; p++) begin
            if (p < poc_pkg::ITEM_REGS &&
                cfg_index == poc_pkg::REG_PATTERN_ITEM_0 + poc_pkg::CFG_INDEX_W'(p)) begin
              items[p] <= cfg_data[poc_pkg::SYMBOL_W-1:0];
            end
          end
        end
      endcase
    end
  end

  // Lengths below two act as two, lengths above the maximum as the maximum.
  always_comb begin
    if (pattern_length < poc_pkg::LENGTH_W'(2)) begin
      last_pos = IDX_W'(1);
    end else if (32'(pattern_length) > 32'(MAX_PATTERN_LEN)) begin
      last_pos = IDX_W'(MAX_PATTERN_LEN - 1);
    end else begin
      last_pos = IDX_W'(pattern_length - poc_pkg::LENGTH_W'(1));
    end
  end

endmodule

// ===== src/poc_pos_counters.sv =====
// ----------------------------------------------------------------------------
// Position counters
// One counter per pattern position with the priority increment rule; the
// counters clear at the end of each sequence.
// ----------------------------------------------------------------------------
module poc_pos_counters #(
  parameter int MAX_PATTERN_LEN = 4,
  parameter int COUNT_BITS = 16,
  parameter int IDX_W = $clog2(MAX_PATTERN_LEN)
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              step,
  input  logic [poc_pkg::SYMBOL_W-1:0]                      symbol,
  input  logic                                              seq_end,
  input  logic [MAX_PATTERN_LEN-1:0][poc_pkg::SYMBOL_W-1:0] items,
  input  logic [IDX_W-1:0]                                  last_pos,
  output logic [COUNT_BITS-1:0]                             occ
);

  logic [MAX_PATTERN_LEN-1:0][COUNT_BITS-1:0] counts;
  logic [MAX_PATTERN_LEN-1:0][COUNT_BITS-1:0] counts_next;
  logic                                       taken;

  always_comb begin
    counts_next = counts;
    taken = 1'b0;
    // Highest matching position whose count trails its predecessor wins.
    for (int m = MAX_PATTERN_LEN - 1; m > 0; m--) begin
      if (!taken && IDX_W'(m) <= last_pos && symbol == items[m] &&
          counts[m] < counts[m-1]) begin
        counts_next[m] = counts[m] + COUNT_BITS'(1);
        taken = 1'b1;
      end
    end
    if (!taken && symbol == items[0] && counts[0] != {COUNT_BITS{1'b1}}) begin
      counts_next[0] = counts[0] + COUNT_BITS'(1);
    end
  end

  assign occ = counts_next[last_pos];

  always_ff @(posedge clk) begin
    if (rst) begin
      counts <= '0;
    end else if (step) begin
      counts <= seq_end ? '0 : counts_next;
    end
  end

endmodule

// ===== src/poc_support_acc.sv =====
// ----------------------------------------------------------------------------
// Support accumulator
// Adds each sequence's occurrences into a saturating total and forms the
// result item, with the support range check at a database end.
// ----------------------------------------------------------------------------
module poc_support_acc #(
  parameter int COUNT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [COUNT_BITS-1:0] occ,
  input  logic                 db_end,
  input  poc_pkg::poc_limits_t limits,
  output poc_pkg::poc_result_t result
);

  logic [poc_pkg::SUPPORT_W-1:0] support_total;
  logic [poc_pkg::SUPPORT_W-1:0] occ_wide;
  logic [poc_pkg::SUPPORT_W:0]   sum;
  logic [poc_pkg::SUPPORT_W-1:0] total_next;
  logic                          meets;

  assign occ_wide = poc_pkg::SUPPORT_W'(occ);
  assign sum = {1'b0, support_total} + {1'b0, occ_wide};
  assign total_next = sum[poc_pkg::SUPPORT_W] ? {poc_pkg::SUPPORT_W{1'b1}}
                                              : sum[poc_pkg::SUPPORT_W-1:0];
  assign meets = db_end && total_next >= limits.min_support;

  always_comb begin
    result.sequence_occurrences = (occ_wide > poc_pkg::SUPPORT_W'({poc_pkg::OCC_W{1'b1}}))
                                  ? {poc_pkg::OCC_W{1'b1}}
                                  : occ_wide[poc_pkg::OCC_W-1:0];
    result.total_support = total_next;
    result.database_done = db_end;
    result.meets_min     = meets;
    result.within_range  = meets && total_next <= limits.max_support;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      support_total <= '0;
    end else if (step) begin
      support_total <= db_end ? '0 : total_next;
    end
  end

endmodule

// ===== src/pattern_occurrence_counter_unit.sv =====
// ----------------------------------------------------------------------------
// Pattern occurrence counter
// Counts non-overlapping occurrences of a configured symbol pattern per
// sequence and keeps a saturating support total over the database.
// ----------------------------------------------------------------------------
// Usage: symbols arrive on the input channel (in_valid/in_ready), one item
// per symbol, with sequence_end marking the last symbol of a sequence and
// database_end the last symbol of the database (it also ends the sequence).
// Only items that end a sequence produce a result item on the output
// channel (out_valid/out_ready); all other items update the per-position
// counters and produce nothing.
// Flow: an accepted item is held in the input register, where the counter
// update and the support addition are done, and its result is then loaded
// into the output register, which drives out_valid.
// Throughput: one item per cycle while no result-producing item is stalled;
// every item updates the counters left by the one before it.
// Stalls: when the output register holds a result that is not taken, an
// item that ends a sequence waits in the input register; items that end no
// sequence still pass through, and in_ready falls only while a result-
// producing item is blocked.
// Reset clears the counters, the support total and the valid flags of both
// registers, and restores the configuration defaults. The configuration port
// is always ready and should be written only while the block is idle.
module pattern_occurrence_counter_unit #(
  parameter int MAX_PATTERN_LEN = 4,
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [poc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [poc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [poc_pkg::SYMBOL_W-1:0]      symbol,
  input  logic                              sequence_end,
  input  logic                              database_end,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [poc_pkg::OCC_W-1:0]         sequence_occurrences,
  output logic [poc_pkg::SUPPORT_W-1:0]     total_support,
  output logic                              database_done,
  output logic                              meets_min,
  output logic                              within_range
);

  localparam int IDX_W = $clog2(MAX_PATTERN_LEN);

  logic [MAX_PATTERN_LEN-1:0][poc_pkg::SYMBOL_W-1:0] items;
  logic [IDX_W-1:0]                                  last_pos;
  poc_pkg::poc_limits_t                              limits;

  // Input register.
  logic                          s1_valid;
  logic [poc_pkg::SYMBOL_W-1:0]  s1_symbol;
  logic                          s1_seq_end;
  logic                          s1_db_end;

  logic                          advance;
  logic [COUNT_BITS-1:0]         occ;
  poc_pkg::poc_result_t          result_comb;
  poc_pkg::poc_result_t          result;

  assign cfg_ready = 1'b1;

  // An item leaves the input register unless it carries a result and the
  // output register is full and not being drained.
  assign advance  = s1_valid && (!s1_seq_end || !out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_symbol  <= symbol;
      // A database end always closes the current sequence as well.
      s1_seq_end <= sequence_end || database_end;
      s1_db_end  <= database_end;
    end
  end

  poc_cfg_regs #(
    .MAX_PATTERN_LEN(MAX_PATTERN_LEN),
    .IDX_W(IDX_W)
  ) u_cfg (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .items(items),
    .last_pos(last_pos),
    .limits(limits)
  );

  poc_pos_counters #(
    .MAX_PATTERN_LEN(MAX_PATTERN_LEN),
    .COUNT_BITS(COUNT_BITS),
    .IDX_W(IDX_W)
  ) u_counters (
    .clk(clk),
    .rst(rst),
    .step(advance),
    .symbol(s1_symbol),
    .seq_end(s1_seq_end),
    .items(items),
    .last_pos(last_pos),
    .occ(occ)
  );

  poc_support_acc #(
    .COUNT_BITS(COUNT_BITS)
  ) u_support (
    .clk(clk),
    .rst(rst),
    .step(advance && s1_seq_end),
    .occ(occ),
    .db_end(s1_db_end),
    .limits(limits),
    .result(result_comb)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_seq_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_seq_end) begin
      result <= result_comb;
    end
  end

  assign sequence_occurrences = result.sequence_occurrences;
  assign total_support        = result.total_support;
  assign database_done        = result.database_done;
  assign meets_min            = result.meets_min;
  assign within_range         = result.within_range;

endmodule
